// ----- sv/mida_pkg.sv -----
// ----------------------------------------------------------------------------
// mida_pkg
// Shared constants, register indexes and types of the multi-input debouncer.
// ----------------------------------------------------------------------------
package mida_pkg;

  localparam int CHANNELS_DEF = 24;
  localparam int BUTTONS_DEF  = 3;

  localparam int RUN_W    = 8;
  localparam int TIMER_W  = 16;
  localparam int CH_SEL_W = 5;

  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [31:0]         ENABLE_RESET    = 32'h00FF_3FE0;
  localparam logic [RUN_W-1:0]    THRESHOLD_RESET = RUN_W'(3);
  localparam logic [TIMER_W-1:0]  HOLD_RESET      = TIMER_W'(2000 / 10);
  localparam int                  BTN_CH_BASE     = 5;

  localparam int REG_CHANNEL_ENABLE   = 0;
  localparam int REG_CHANGE_THRESHOLD = 1;
  localparam int REG_HOLD_TICKS       = 2;
  localparam int REG_BUTTON_BASE      = 3;

  typedef struct packed {
    logic level;
    logic level_nxt;
    logic changed;
  } chan_res_t;

  typedef struct packed {
    logic pressed;
    logic released;
    logic long_pressed;
  } btn_flags_t;

endpackage

// ----- sv/mida_chan.sv -----
// ----------------------------------------------------------------------------
// mida_chan
// One debounced channel: run counter of differing samples and stable level.
// ----------------------------------------------------------------------------
module mida_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        enable,
  input  logic                        raw_bit,
  input  logic [mida_pkg::RUN_W-1:0]  threshold,
  output mida_pkg::chan_res_t         res
);
  import mida_pkg::*;

  logic             level_r;
  logic             level_nxt;
  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_nxt;
  logic [RUN_W-1:0] run_inc;
  logic             mismatch;
  logic             accept;

  always_comb begin
    mismatch  = raw_bit ^ level_r;
    run_inc   = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
    accept    = enable && mismatch && (run_inc >= threshold);
    run_nxt   = run_r;
    if (enable) begin
      run_nxt = mismatch ? run_inc : '0;
    end
    level_nxt = accept ? raw_bit : level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      run_r   <= '0;
    end else if (step) begin
      level_r <= level_nxt;
      run_r   <= run_nxt;
    end
  end

  assign res.level     = level_r;
  assign res.level_nxt = level_nxt;
  assign res.changed   = accept;

endmodule

// ----- sv/mida_btn.sv -----
// ----------------------------------------------------------------------------
// mida_btn
// One long-press timer watching a selectable debounced channel.
// ----------------------------------------------------------------------------
module mida_btn #(
  parameter int CHANNELS = mida_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [CHANNELS-1:0]           changed,
  input  logic [CHANNELS-1:0]           levels_nxt,
  input  logic [mida_pkg::CH_SEL_W-1:0] channel,
  input  logic [mida_pkg::TIMER_W-1:0]  hold_ticks,
  output mida_pkg::btn_flags_t          flags
);
  import mida_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TIMER_W-1:0] timer_r;
  logic [TIMER_W-1:0] timer_nxt;
  logic [TIMER_W-1:0] timer_adv;
  logic               advance;
  logic               in_range;
  logic [IDX_W-1:0]   sel;
  logic               hit;
  logic               level;

  always_comb begin
    advance   = (timer_r != '0) && (timer_r != TIMER_MAX);
    timer_adv = advance ? timer_r + 1'b1 : timer_r;
    in_range  = {1'b0, channel} < (CH_SEL_W + 1)'(CHANNELS);
    sel       = channel[IDX_W-1:0];
    hit       = in_range && changed[sel];
    level     = levels_nxt[sel];
    timer_nxt = timer_adv;
    if (hit) begin
      timer_nxt = level ? '0 : TIMER_W'(1);
    end
    flags.long_pressed = advance && (timer_adv == hold_ticks);
    flags.pressed      = hit && !level;
    flags.released     = hit && level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
    end else if (step) begin
      timer_r <= timer_nxt;
    end
  end

endmodule

// ----- sv/multi_input_debouncer_long_press.sv -----
// ----------------------------------------------------------------------------
// multi_input_debouncer_long_press
// Multi-channel switch debouncer with per-button long-press timers.
// ----------------------------------------------------------------------------
// Each item on the in_ channel is one tick's raw sample of all channels. The
// item updates the run counters, debounced levels and long-press timers, and
// one result item per input item appears on the out_ channel in the cycle after
// acceptance: debounced levels, changed mask and press, release and
// long-press flags. Throughput is one item per cycle while out_ready stays
// high, set by the single result register that holds the outcome of each tick.
// The result register also decouples the sides: a new item is taken while a
// result is presented if the receiver takes that result in the same cycle.
// When the receiver stalls, the held result stays unchanged and in_ready
// drops until it is taken, so no item is lost or repeated.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata at any
// cycle with no wait; it should only change while the block is idle.
// Synchronous reset clears all levels, counters and timers, restores the
// default configuration and empties the result register.
// ----------------------------------------------------------------------------
module multi_input_debouncer_long_press #(
  parameter int CHANNELS = mida_pkg::CHANNELS_DEF,
  parameter int BUTTONS  = mida_pkg::BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CHANNELS-1:0] in_raw_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHANNELS-1:0] out_stable_levels,
  output logic [CHANNELS-1:0] out_changed_mask,
  output logic [BUTTONS-1:0]  out_press_flags,
  output logic [BUTTONS-1:0]  out_release_flags,
  output logic [BUTTONS-1:0]  out_long_press_flags,
  input  logic                cfg_wr_en,
  input  logic [$clog2(mida_pkg::REG_BUTTON_BASE + BUTTONS)-1:0] cfg_index,
  input  logic [((CHANNELS > mida_pkg::TIMER_W) ? CHANNELS : mida_pkg::TIMER_W)-1:0] cfg_wdata
);
  import mida_pkg::*;

  localparam int IDX_W = $clog2(REG_BUTTON_BASE + BUTTONS);

  logic [CHANNELS-1:0] enable_r;
  logic [RUN_W-1:0]    threshold_r;
  logic [TIMER_W-1:0]  hold_r;
  logic [CH_SEL_W-1:0] btn_ch_r [BUTTONS];

  logic                in_fire;
  chan_res_t           chan_res [CHANNELS];
  btn_flags_t          btn_flags [BUTTONS];
  logic [CHANNELS-1:0] levels;
  logic [CHANNELS-1:0] levels_nxt;
  logic [CHANNELS-1:0] changed;
  logic [BUTTONS-1:0]  press;
  logic [BUTTONS-1:0]  rel;
  logic [BUTTONS-1:0]  longp;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CHANNELS-1:0] stable_r;
  logic [CHANNELS-1:0] changed_r;
  logic [BUTTONS-1:0]  press_r;
  logic [BUTTONS-1:0]  rel_r;
  logic [BUTTONS-1:0]  longp_r;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= ENABLE_RESET[CHANNELS-1:0];
      threshold_r <= THRESHOLD_RESET;
      hold_r      <= HOLD_RESET;
      for (int k = 0; k < BUTTONS; k++) begin
        btn_ch_r[k] <= CH_SEL_W'(BTN_CH_BASE + k);
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == IDX_W'(REG_CHANNEL_ENABLE)) begin
        enable_r <= cfg_wdata[CHANNELS-1:0];
      end
      if (cfg_index == IDX_W'(REG_CHANGE_THRESHOLD)) begin
        threshold_r <= cfg_wdata[RUN_W-1:0];
      end
      if (cfg_index == IDX_W'(REG_HOLD_TICKS)) begin
        hold_r <= cfg_wdata[TIMER_W-1:0];
      end
      for (int k = 0; k < BUTTONS; k++) begin
        if (cfg_index == IDX_W'(REG_BUTTON_BASE + k)) begin
          btn_ch_r[k] <= cfg_wdata[CH_SEL_W-1:0];
        end
      end
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : gen_chan
    mida_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (in_fire),
      .enable    (enable_r[i]),
      .raw_bit   (in_raw_sample[i]),
      .threshold (threshold_r),
      .res       (chan_res[i])
    );
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      levels[i]     = chan_res[i].level;
      levels_nxt[i] = chan_res[i].level_nxt;
      changed[i]    = chan_res[i].changed;
    end
  end

  for (genvar k = 0; k < BUTTONS; k++) begin : gen_btn
    mida_btn #(
      .CHANNELS (CHANNELS)
    ) u_btn (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (in_fire),
      .changed    (changed),
      .levels_nxt (levels_nxt),
      .channel    (btn_ch_r[k]),
      .hold_ticks (hold_r),
      .flags      (btn_flags[k])
    );
  end

  always_comb begin
    for (int k = 0; k < BUTTONS; k++) begin
      press[k] = btn_flags[k].pressed;
      rel[k]   = btn_flags[k].released;
      longp[k] = btn_flags[k].long_pressed;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stable_r  <= levels_nxt;
      changed_r <= changed;
      press_r   <= press;
      rel_r     <= rel;
      longp_r   <= longp;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stable_levels    = stable_r;
  assign out_changed_mask     = changed_r;
  assign out_press_flags      = press_r;
  assign out_release_flags    = rel_r;
  assign out_long_press_flags = longp_r;

`ifndef SYNTHESIS
  a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_flags & out_release_flags) == '0))
    else $error("press and release flagged for the same button");

  a_change_matches_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_fire) |=> ((out_stable_levels ^ $past(levels)) == out_changed_mask))
    else $error("changed mask does not match toggled levels");

  a_change_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_fire) |=> ((out_changed_mask & ~$past(enable_r)) == '0))
    else $error("disabled channel reported a change");
`endif

endmodule
